/* src/rgtd_pkg.sv */
// shared types and constants of the rds group text decoder
package rgtd_pkg;

    localparam int PS_CHARS = 8;
    localparam int RT_CHARS = 64;
    localparam int RT_ROW_CHARS = 4;
    localparam int RT_ROWS = RT_CHARS / RT_ROW_CHARS;
    localparam int RT_DEPTH = 2 * RT_ROWS;
    localparam int RT_ROW_BITS = 8 * RT_ROW_CHARS;
    localparam int RT_ADDR_BITS = $clog2(RT_DEPTH);

    localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd10;

    localparam logic [1:0] KIND_BLOCK   = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_READ_PS = 2'd2;
    localparam logic [1:0] KIND_READ_RT = 2'd3;

    localparam logic [2:0] BLK_A  = 3'd0;
    localparam logic [2:0] BLK_B  = 3'd1;
    localparam logic [2:0] BLK_C  = 3'd2;
    localparam logic [2:0] BLK_D  = 3'd3;
    localparam logic [2:0] BLK_CP = 3'd4;

    localparam logic [3:0] GROUP_PS = 4'd0;
    localparam logic [3:0] GROUP_RT = 4'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  block_id;
        logic [15:0] block_word;
        logic [5:0]  char_index;
        logic        clear_new;
    } item_word_t;

    typedef struct packed {
        logic        group_done;
        logic [15:0] pi_code;
        logic        station_new;
        logic        text_new;
        logic        active_page;
        logic        rds_present;
        logic [7:0]  char_out;
    } result_word_t;

endpackage

/* src/rgtd_ram.sv */
// generic ram, one write port and two registered read ports
module rgtd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_a_en,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    output logic [WIDTH-1:0]         rd_a_data,
    input  logic                     rd_b_en,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_data <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

/* src/rds_group_text_decoder.sv */
// rds group text decoder: group assembly, station name and radio text stores
// pipeline: input register then result register; an accepted word waits in the
//   input register until the result register can take it, so result stalls hold it there
// throughput: one word per cycle while result_stall is low; the radio text ram has one read port for reads
//   and one that prefetches the row addressed by the stored block b
// reset: asynchronous, clears assembler, pi, flags, station chars and the row
//   valid bits of the radio text ram at once; no clearing pass
module rds_group_text_decoder
    import rgtd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  item_word_t   item_word,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result_word,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data
);

    localparam logic [1:0] EXP_A = 2'd0;
    localparam logic [1:0] EXP_B = 2'd1;
    localparam logic [1:0] EXP_C = 2'd2;
    localparam logic [1:0] EXP_D = 2'd3;

    // pipeline registers
    logic         s1_valid_reg;
    item_word_t   s1_word_reg;
    logic         out_valid_reg;
    result_word_t out_word_reg;
    logic                   byp_hit_reg, byp_hit_next;
    logic [RT_ROW_BITS-1:0] byp_data_reg;

    // decoder state
    logic [7:0]  limit_reg;
    logic [1:0]  expect_reg, expect_next;
    logic [15:0] gw_reg [3];
    logic [15:0] gw_next [3];
    logic [15:0] pi_reg, pi_next;
    logic [7:0]  station_reg [PS_CHARS];
    logic [7:0]  station_next [PS_CHARS];
    logic [1:0][RT_ROWS-1:0] rt_valid_reg, rt_valid_next;
    logic [2:0]  flags_reg, flags_next;
    logic        page_reg, page_next;
    logic [7:0]  tcount_reg, tcount_next;
    logic        present_reg, present_next;

    logic proc;
    logic accept;

    // ram signals
    logic                    ram_we;
    logic [RT_ADDR_BITS-1:0] ram_waddr;
    logic [RT_ROW_BITS-1:0]  ram_wdata;
    logic [RT_ADDR_BITS-1:0] rd_addr_a;
    logic [RT_ROW_BITS-1:0]  ram_a_data;
    logic [RT_ROW_BITS-1:0]  ram_b_data;

    // group decode
    logic        pi_change;
    logic [15:0] wb, wc, wd;
    logic        rt_pg;
    logic [3:0]  rt_row;
    logic [7:0]  st_work [PS_CHARS];
    logic        st_hit;
    logic [3:0][7:0] row_old, row_new, row_work;
    logic [3:0]  row_mask;
    logic        rt_hit;
    logic [1:0][RT_ROWS-1:0] rt_valid_dec;

    // read and timeout
    logic [7:0]  tcount_inc;
    logic [RT_ROW_BITS-1:0] rd_row;
    logic [7:0]  ch;
    logic        done;
    logic [2:0]  flags_out;

    assign proc       = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !proc;
    assign accept     = item_valid && !item_stall;

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    // decode of a completed group, from the stored a, b, c words and this d word
    assign wb = gw_reg[1];
    assign wc = gw_reg[2];
    assign wd = s1_word_reg.block_word;
    assign pi_change = gw_reg[0] != pi_reg;
    assign rt_pg  = wb[4];
    assign rt_row = wb[11] ? {1'b0, wb[3:1]} : wb[3:0];

    always_comb
    begin
        if (pi_change)
        begin
            st_work = '{default: '0};
        end
        else
        begin
            st_work = station_reg;
        end
        st_hit  = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            logic [2:0] pos;
            logic [7:0] c;
            pos = {wb[1:0], 1'b0} + 3'(i);
            c   = (i == 0) ? wd[15:8] : wd[7:0];
            if (st_work[pos] != 8'd0 && st_work[pos] != c)
            begin
                st_work = '{default: '0};
                st_hit  = 1'b1;
            end
            st_work[pos] = c;
        end
    end

    always_comb
    begin
        for (int i = 0; i < RT_ROW_CHARS; i++)
        begin
            row_old[i] = (rt_valid_reg[rt_pg][rt_row] && !pi_change)
                ? ram_b_data[8*i +: 8] : 8'd0;
        end
        if (wb[11])
        begin
            row_new  = '0;
            row_mask = wb[0] ? 4'b1100 : 4'b0011;
            if (wb[0])
            begin
                row_new[2] = wd[15:8];
                row_new[3] = wd[7:0];
            end
            else
            begin
                row_new[0] = wd[15:8];
                row_new[1] = wd[7:0];
            end
        end
        else
        begin
            row_mask   = 4'b1111;
            row_new[0] = wc[15:8];
            row_new[1] = wc[7:0];
            row_new[2] = wd[15:8];
            row_new[3] = wd[7:0];
        end
        // a conflict wipes the whole page, chars already placed included
        row_work = row_old;
        rt_hit   = 1'b0;
        for (int i = 0; i < RT_ROW_CHARS; i++)
        begin
            if (row_mask[i])
            begin
                if (row_work[i] != 8'd0 && row_work[i] != row_new[i])
                begin
                    row_work = '0;
                    rt_hit   = 1'b1;
                end
                row_work[i] = row_new[i];
            end
        end
        rt_valid_dec = pi_change ? '0 : rt_valid_reg;
        if (rt_hit)
        begin
            rt_valid_dec[rt_pg] = '0;
        end
        rt_valid_dec[rt_pg][rt_row] = 1'b1;
    end

    assign tcount_inc = (tcount_reg == 8'hFF) ? tcount_reg : tcount_reg + 8'd1;
    assign rd_row     = byp_hit_reg ? byp_data_reg : ram_a_data;

    always_comb
    begin
        expect_next   = expect_reg;
        gw_next       = gw_reg;
        pi_next       = pi_reg;
        station_next  = station_reg;
        rt_valid_next = rt_valid_reg;
        flags_next    = flags_reg;
        page_next     = page_reg;
        tcount_next   = tcount_reg;
        present_next  = present_reg;
        ram_we        = 1'b0;
        ram_waddr     = {rt_pg, rt_row};
        ram_wdata     = row_work;
        done          = 1'b0;
        ch            = 8'd0;
        flags_out     = flags_reg;
        if (proc)
        begin
            unique case (s1_word_reg.kind)
                KIND_BLOCK:
                begin
                    present_next = 1'b1;
                    tcount_next  = 8'd0;
                    unique case (s1_word_reg.block_id)
                        BLK_A:
                        begin
                            gw_next[0]  = wd;
                            expect_next = EXP_B;
                        end
                        BLK_B:
                        begin
                            if (expect_reg == EXP_B)
                            begin
                                gw_next[1]  = wd;
                                expect_next = EXP_C;
                            end
                            else
                            begin
                                expect_next = EXP_A;
                            end
                        end
                        BLK_C:
                        begin
                            if (expect_reg == EXP_C)
                            begin
                                gw_next[2]  = wd;
                                expect_next = EXP_D;
                            end
                            else
                            begin
                                expect_next = EXP_A;
                            end
                        end
                        BLK_CP:
                        begin
                            expect_next = (expect_reg == EXP_C) ? EXP_D : EXP_A;
                        end
                        BLK_D:
                        begin
                            expect_next = EXP_A;
                            if (expect_reg == EXP_D)
                            begin
                                done    = 1'b1;
                                pi_next = gw_reg[0];
                                if (pi_change)
                                begin
                                    station_next  = '{default: '0};
                                    rt_valid_next = '0;
                                end
                                if (wb[15:12] == GROUP_PS)
                                begin
                                    station_next = st_work;
                                    if (st_hit)
                                    begin
                                        flags_next[0] = 1'b1;
                                    end
                                end
                                else if (wb[15:12] == GROUP_RT)
                                begin
                                    rt_valid_next = rt_valid_dec;
                                    ram_we        = 1'b1;
                                    page_next     = rt_pg;
                                    if (rt_hit)
                                    begin
                                        flags_next[{1'b0, rt_pg} + 2'd1] = 1'b1;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    flags_out = flags_next;
                end
                KIND_TIMEOUT:
                begin
                    tcount_next = tcount_inc;
                    if (tcount_inc > limit_reg)
                    begin
                        station_next  = '{default: '0};
                        rt_valid_next = '0;
                        pi_next       = 16'd0;
                        present_next  = 1'b0;
                    end
                end
                KIND_READ_PS:
                begin
                    if (s1_word_reg.char_index[5:3] == 3'd0)
                    begin
                        ch = station_reg[s1_word_reg.char_index[2:0]];
                    end
                    if (s1_word_reg.clear_new)
                    begin
                        flags_next[0] = 1'b0;
                    end
                end
                KIND_READ_RT:
                begin
                    if (rt_valid_reg[page_reg][s1_word_reg.char_index[5:2]])
                    begin
                        ch = rd_row[8*s1_word_reg.char_index[1:0] +: 8];
                    end
                    if (s1_word_reg.clear_new)
                    begin
                        flags_next[{1'b0, page_reg} + 2'd1] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // read address uses the page as left by the word now finishing
    assign rd_addr_a    = {page_next, item_word.char_index[5:2]};
    assign byp_hit_next = ram_we && (ram_waddr == rd_addr_a);

    rgtd_ram #(
        .WIDTH(RT_ROW_BITS),
        .DEPTH(RT_DEPTH)
    ) u_rt_ram (
        .clk       (clk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_a_en   (accept),
        .rd_a_addr (rd_addr_a),
        .rd_a_data (ram_a_data),
        .rd_b_en   (1'b1),
        .rd_b_addr ({rt_pg, rt_row}),
        .rd_b_data (ram_b_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= TIMEOUT_LIMIT_RESET;
            expect_reg    <= EXP_A;
            gw_reg        <= '{default: '0};
            pi_reg        <= 16'd0;
            station_reg   <= '{default: '0};
            rt_valid_reg  <= '0;
            flags_reg     <= 3'd0;
            page_reg      <= 1'b0;
            tcount_reg    <= 8'd0;
            present_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            expect_reg   <= expect_next;
            gw_reg       <= gw_next;
            pi_reg       <= pi_next;
            station_reg  <= station_next;
            rt_valid_reg <= rt_valid_next;
            flags_reg    <= flags_next;
            page_reg     <= page_next;
            tcount_reg   <= tcount_next;
            present_reg  <= present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg  <= item_word;
            byp_hit_reg  <= byp_hit_next;
            byp_data_reg <= ram_wdata;
        end
        if (proc)
        begin
            out_word_reg.group_done  <= done;
            out_word_reg.pi_code     <= pi_next;
            out_word_reg.station_new <= flags_out[0];
            out_word_reg.text_new    <= page_next ? flags_out[2] : flags_out[1];
            out_word_reg.active_page <= page_next;
            out_word_reg.rds_present <= present_next;
            out_word_reg.char_out    <= ch;
        end
    end

endmodule

/* dv/tb.sv */
// testbench of the rds group text decoder: stimulus, text store predictor and result checks
`timescale 1ns / 1ps

module tb;
    import rgtd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [1:0] {WANT_A, WANT_B, WANT_C, WANT_D} asm_state_t;

    // predicts each result word and keeps the words still to come
    class text_scoreboard;
        logic [7:0]   limit;
        asm_state_t   assembling;
        logic [15:0]  grp [3];
        logic [15:0]  pi;
        logic [7:0]   ps [PS_CHARS];
        logic [7:0]   rt [2 * RT_CHARS];
        logic [2:0]   flags;
        logic         page;
        logic [7:0]   tcount;
        logic         present;
        result_word_t waiting_q [$];
        int           errors;
        int           checked;
        int           groups;
        int           reads;

        function new();
            limit = TIMEOUT_LIMIT_RESET;
            assembling = WANT_A;
            foreach (grp[i]) grp[i] = '0;
            pi = '0;
            clear_text();
            flags = '0;
            page = 1'b0;
            tcount = '0;
            present = 1'b0;
            errors = 0;
            checked = 0;
            groups = 0;
            reads = 0;
        endfunction

        function void set_limit(logic [7:0] v);
            limit = v;
        endfunction

        function int outstanding();
            return waiting_q.size();
        endfunction

        function void clear_text();
            foreach (ps[i]) ps[i] = '0;
            foreach (rt[i]) rt[i] = '0;
        endfunction

        // a char that differs from a nonzero stored char wipes the whole buffer and marks it new
        function void store_char(bit to_text, bit pg, int unsigned pos, logic [7:0] c);
            int unsigned len;
            int unsigned base;
            logic [7:0]  old;
            int          i;
            len = to_text ? RT_CHARS : PS_CHARS;
            base = pg * RT_CHARS;
            if (pos >= len)
                return;
            old = to_text ? rt[base + pos] : ps[pos];
            if (old != 8'h00 && old != c)
            begin
                if (to_text)
                begin
                    for (i = 0; i < RT_CHARS; i++)
                        rt[base + i] = '0;
                    flags[1 + pg] = 1'b1;
                end
                else
                begin
                    for (i = 0; i < PS_CHARS; i++)
                        ps[i] = '0;
                    flags[0] = 1'b1;
                end
            end
            if (to_text)
                rt[base + pos] = c;
            else
                ps[pos] = c;
        endfunction

        function void apply_group(logic [15:0] wd);
            logic [15:0] wb;
            logic [15:0] wc;
            int unsigned off;
            bit          pg;
            wb = grp[1];
            wc = grp[2];
            if (grp[0] != pi)
            begin
                clear_text();
                pi = grp[0];
            end
            if (wb[15:12] == GROUP_PS)
            begin
                off = 2 * wb[1:0];
                store_char(1'b0, 1'b0, off, wd[15:8]);
                store_char(1'b0, 1'b0, off + 1, wd[7:0]);
            end
            else if (wb[15:12] == GROUP_RT)
            begin
                pg = wb[4];
                if (wb[11])
                begin
                    off = 2 * wb[3:0];
                    store_char(1'b1, pg, off, wd[15:8]);
                    store_char(1'b1, pg, off + 1, wd[7:0]);
                end
                else
                begin
                    off = 4 * wb[3:0];
                    store_char(1'b1, pg, off, wc[15:8]);
                    store_char(1'b1, pg, off + 1, wc[7:0]);
                    store_char(1'b1, pg, off + 2, wd[15:8]);
                    store_char(1'b1, pg, off + 3, wd[7:0]);
                end
                page = pg;
            end
        endfunction

        function void note_item(item_word_t w);
            result_word_t r;
            logic [2:0]   shown;
            logic         done;
            logic [7:0]   ch;
            done = 1'b0;
            ch = '0;
            shown = flags;
            case (w.kind)
                KIND_BLOCK:
                begin
                    present = 1'b1;
                    tcount = '0;
                    case (w.block_id)
                        BLK_A:
                        begin
                            grp[0] = w.block_word;
                            assembling = WANT_B;
                        end
                        BLK_B:
                        begin
                            if (assembling == WANT_B)
                            begin
                                grp[1] = w.block_word;
                                assembling = WANT_C;
                            end
                            else
                                assembling = WANT_A;
                        end
                        BLK_C:
                        begin
                            if (assembling == WANT_C)
                            begin
                                grp[2] = w.block_word;
                                assembling = WANT_D;
                            end
                            else
                                assembling = WANT_A;
                        end
                        BLK_CP:
                            assembling = (assembling == WANT_C) ? WANT_D : WANT_A;
                        BLK_D:
                        begin
                            if (assembling == WANT_D)
                            begin
                                apply_group(w.block_word);
                                done = 1'b1;
                                groups++;
                            end
                            assembling = WANT_A;
                        end
                        default: ;
                    endcase
                    shown = flags;
                end
                KIND_TIMEOUT:
                begin
                    if (tcount != 8'hFF)
                        tcount = tcount + 8'd1;
                    if (tcount > limit)
                    begin
                        clear_text();
                        pi = '0;
                        present = 1'b0;
                    end
                    shown = flags;
                end
                KIND_READ_PS:
                begin
                    if (w.char_index < PS_CHARS)
                        ch = ps[w.char_index];
                    shown = flags;
                    if (w.clear_new)
                        flags[0] = 1'b0;
                    reads++;
                end
                default:
                begin
                    ch = rt[page * RT_CHARS + w.char_index];
                    shown = flags;
                    if (w.clear_new)
                        flags[1 + page] = 1'b0;
                    reads++;
                end
            endcase
            r.group_done = done;
            r.pi_code = pi;
            r.station_new = shown[0];
            r.text_new = shown[1 + page];
            r.active_page = page;
            r.rds_present = present;
            r.char_out = ch;
            waiting_q.push_back(r);
        endfunction

        function void cmp(string name, logic [15:0] e, logic [15:0] a);
            if (e !== a)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(result_word_t a);
            result_word_t e;
            if (waiting_q.size() == 0)
            begin
                $error("result word with nothing expected: %0h", a);
                errors++;
                return;
            end
            e = waiting_q.pop_front();
            checked++;
            cmp("group_done", 16'(e.group_done), 16'(a.group_done));
            cmp("pi_code", e.pi_code, a.pi_code);
            cmp("station_new", 16'(e.station_new), 16'(a.station_new));
            cmp("text_new", 16'(e.text_new), 16'(a.text_new));
            cmp("active_page", 16'(e.active_page), 16'(a.active_page));
            cmp("rds_present", 16'(e.rds_present), 16'(a.rds_present));
            cmp("char_out", 16'(e.char_out), 16'(a.char_out));
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_stall;
    item_word_t   item_word;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result_word;
    logic         cfg_wr_en;
    logic [7:0]   cfg_wr_data;

    text_scoreboard sb;
    int           items_sent = 0;
    int           cycle_count = 0;
    bit           quiet = 1'b0;
    bit           hold_go = 1'b0;
    bit           hold_req = 1'b0;
    logic [15:0]  main_pi = 16'h0000;
    logic [15:0]  pi_pool [3] = '{16'h0000, 16'hFFFF, 16'hC201};
    logic         last_page = 1'b0;
    logic [7:0]   last_limit = '0;

    rds_group_text_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_word    (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_word);

    always @(negedge clk)
        result_stall <= hold_req || (!quiet && $urandom_range(0, 99) < 8);

    // long receiver hold-off so the block fills up and pushes back
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_req = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
    end

    function automatic item_word_t rand_item();
        logic [31:0] r;
        r = $urandom;
        return r[$bits(item_word_t)-1:0];
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        if (r < 85)
            return 8'h41 + 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // entered and left at a falling edge
    task automatic send(input item_word_t w);
        if (!quiet && $urandom_range(0, 99) < 8)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item_valid <= 1'b1;
        item_word <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(w);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_block(input logic [2:0] id, input logic [15:0] word);
        item_word_t w;
        w = rand_item();
        w.kind = KIND_BLOCK;
        w.block_id = id;
        w.block_word = word;
        send(w);
    endtask

    task automatic send_read(input logic [1:0] kind, input logic [5:0] idx, input logic clr);
        item_word_t w;
        w = rand_item();
        w.kind = kind;
        w.char_index = idx;
        w.clear_new = clr;
        send(w);
    endtask

    task automatic send_timeout();
        item_word_t w;
        w = rand_item();
        w.kind = KIND_TIMEOUT;
        send(w);
    endtask

    task automatic send_group(input logic [15:0] pi, input logic [15:0] bw,
                              input logic [15:0] cw, input bit use_cp,
                              input logic [15:0] dw, input bit broken);
        logic [2:0]  ids [4];
        logic [15:0] wds [4];
        int          i;
        ids = '{BLK_A, BLK_B, use_cp ? BLK_CP : BLK_C, BLK_D};
        wds = '{pi, bw, cw, dw};
        if (broken)
            ids[$urandom_range(0, 3)] = 3'($urandom_range(0, 7));
        for (i = 0; i < 4; i++)
            send_block(ids[i], wds[i]);
    endtask

    task automatic send_random_group();
        logic [15:0] pi;
        logic [15:0] bw;
        int          r;
        r = $urandom_range(0, 99);
        pi = (r < 80) ? main_pi : (r < 95) ? pi_pool[$urandom_range(0, 2)] : 16'($urandom);
        bw = 16'($urandom);
        r = $urandom_range(0, 99);
        bw[15:12] = (r < 40) ? GROUP_PS : (r < 85) ? GROUP_RT : 4'($urandom_range(0, 15));
        if (bw[15:12] == GROUP_RT)
        begin
            bw[4] = ($urandom_range(0, 99) < 70) ? last_page : ~last_page;
            last_page = bw[4];
        end
        send_group(pi, bw, {rand_char(), rand_char()}, $urandom_range(0, 99) < 15,
                   {rand_char(), rand_char()}, $urandom_range(0, 99) < 10);
    endtask

    task automatic run_traffic(input int count);
        int stop_at;
        int r;
        int n;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 58)
                send_random_group();
            else if (r < 68)
                send_read(KIND_READ_PS, ($urandom_range(0, 3) == 0) ?
                          6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7)),
                          $urandom_range(0, 3) == 0);
            else if (r < 78)
                send_read(KIND_READ_RT, 6'($urandom_range(0, 63)), $urandom_range(0, 3) == 0);
            else if (r < 86)
            begin
                n = ($urandom_range(0, 3) == 0) ? int'(sb.limit) + 2 : $urandom_range(1, 4);
                if (n > 30)
                    n = 30;
                repeat (n) send_timeout();
            end
            else
                send(rand_item());
        end
    endtask

    // wait until every expected word is back, then let the pipeline settle
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        sb.set_limit(v);
        last_limit = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_word = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty reads, 0B with c prime, station conflict, pi change, top row of
        // text page 1, last 2B position of page 0, ignored and out of order blocks
        send_read(KIND_READ_RT, 6'd63, 1'b1);
        send_group(16'hFFFF, 16'h0803, 16'h0000, 1'b1, 16'hFFFF, 1'b0);
        send_group(16'hFFFF, 16'h0003, 16'h1234, 1'b0, 16'h4142, 1'b0);
        send_read(KIND_READ_PS, 6'd7, 1'b1);
        send_read(KIND_READ_PS, 6'd63, 1'b0);
        send_group(16'h0000, 16'h201F, 16'h0000, 1'b0, 16'h5A5A, 1'b0);
        send_group(16'h0000, 16'h280F, 16'hFFFF, 1'b1, 16'h2020, 1'b0);
        send_read(KIND_READ_RT, 6'd31, 1'b1);
        send_block(3'd7, 16'hFFFF);
        send_block(3'd5, 16'h0000);
        send_block(BLK_B, 16'h2000);
        send_block(BLK_D, 16'hFFFF);
        send_timeout();
        drain();

        write_limit(8'd0);
        main_pi = 16'($urandom);
        run_traffic(200);
        drain();

        // saturating timeout count never exceeds the top limit
        write_limit(8'd255);
        main_pi = pi_pool[1];
        repeat (260) send_timeout();
        quiet = 1'b1;
        run_traffic(100);
        quiet = 1'b0;
        run_traffic(50);
        drain();

        write_limit(8'd3);
        main_pi = 16'($urandom);
        hold_go = 1'b1;
        run_traffic(200);
        drain();

        write_limit(8'($urandom_range(1, 20)));
        main_pi = pi_pool[0];
        run_traffic(300);
        drain();

        $display("covered %0d words in, %0d results checked, %0d groups decoded, %0d char reads",
                 items_sent, sb.checked, sb.groups, sb.reads);
        $display("timeout limits 10, 0, 255, 3 and %0d; one %0d cycle receiver hold-off",
                 last_limit, HOLD_CYCLES);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
